>>> hw/rtl/wyh_pkg.sv
// wyh_pkg: shared types, constants and byte-select helpers for the wyhash core.
// No dependencies; imported by every module of the block.
package wyh_pkg;

    localparam logic [63:0] SECRET0 = 64'h2d358dccaa6c78a5;
    localparam logic [63:0] SECRET1 = 64'h8bb84b93962eacc9;
    localparam logic [63:0] SECRET2 = 64'h4b33a62ed433d4a3;
    localparam logic [63:0] SECRET3 = 64'h4d5a2da51de1aa47;
    localparam int BLOCK_BYTES = 48;
    localparam int ROUND_BYTES = 16;

    typedef struct packed {
        logic [63:0] word;
        logic [31:0] len;
        logic [63:0] seed;
        logic        first;
        logic        empty;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } mul_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADV, ST_MRD, ST_MGO, ST_MWAIT, ST_CHECK,
        ST_FRD0, ST_FRD1, ST_FOPS, ST_FM1W, ST_FM2GO, ST_FM2W, ST_FOUT
    } back_state_t;

    // Four little-endian bytes starting at byte idx of a 16-byte buffer.
    function automatic logic [31:0] le4(input logic [127:0] w, input logic [3:0] idx);
        logic [127:0] s;
        s = w >> {idx, 3'b000};
        return s[31:0];
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] w, input logic [3:0] idx);
        logic [127:0] s;
        s = w >> {idx, 3'b000};
        return s[7:0];
    endfunction

endpackage

>>> hw/rtl/wyh_front.sv
// wyh_front: accepts stream words, tags them and holds them in a two-entry queue.
// Depends on wyh_pkg.
module wyh_front #(
    parameter int LEN_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [63:0]    in_word,
    input  logic [31:0]    in_len,
    input  logic [63:0]    in_seed,
    input  logic           in_first,
    output logic           q_valid,
    output wyh_pkg::item_t q_item,
    input  logic           q_pop
);
    import wyh_pkg::*;

    localparam logic [31:0] LEN_MASK = (LEN_BITS >= 32) ? 32'hffffffff
                                     : 32'((64'd1 << LEN_BITS) - 64'd1);

    item_t       fifo_mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;
    item_t       in_item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb begin
        in_item.word  = in_word;
        in_item.len   = in_len & LEN_MASK;
        in_item.seed  = in_seed;
        in_item.first = in_first;
        in_item.empty = in_first && ((in_len & LEN_MASK) == 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> hw/rtl/wyh_mul.sv
// wyh_mul: iterative 64x64 multiply-fold, one 32x32 partial product per cycle.
// Depends on wyh_pkg.
module wyh_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  wyh_pkg::mul_req_t   req,
    output wyh_pkg::mul_stat_t  stat
);
    import wyh_pkg::*;

    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_k_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [63:0]  res_reg;
    logic [31:0]  xa, ya;
    logic [127:0] acc_next;
    logic [127:0] pp_ext;

    always_comb begin
        xa = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        ya = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        case (pp_k_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd3:    pp_ext = {pp_reg, 64'd0};
            default: pp_ext = {32'd0, pp_reg, 32'd0};
        endcase
        acc_next = acc_reg + pp_ext;
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
        end else if (busy_reg) begin
            pp_reg   <= xa * ya;
            pp_k_reg <= cnt_reg[1:0];
            if (cnt_reg != 3'd0) acc_reg <= acc_next;
            if (cnt_reg == 3'd4) res_reg <= acc_next[63:0] ^ acc_next[127:64];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.result = res_reg;
endmodule

>>> hw/rtl/wyh_back.sv
// wyh_back: window memory, lane accumulators and the mixing/finish sequencer.
// Depends on wyh_pkg and wyh_mul.
module wyh_back #(
    parameter int LEN_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  wyh_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    out_hash
);
    import wyh_pkg::*;

    localparam int LEN_W = (LEN_BITS < 32) ? LEN_BITS : 32;

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] bt_reg, bt_next;
    logic [LEN_W-1:0] done_reg, done_next;
    logic [63:0]      main_reg, main_next, second_reg, second_next, third_reg, third_next;
    logic             bulk_reg, bulk_next;
    logic [1:0]       lane_reg, lane_next;
    logic [63:0]      buf0_reg, buf0_next, buf1_reg, buf1_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      out_data_reg, out_data_next;

    logic [63:0]      win_mem [8];
    logic [63:0]      rd0_reg, rd1_reg;
    logic [2:0]       ra0, ra1;
    logic             wr_en;
    logic [2:0]       wr_addr;

    mul_req_t         mreq;
    mul_stat_t        mstat;

    logic [LEN_W-1:0] rem, avail, tail_off, item_len;
    logic [2:0]       fq;
    logic [127:0]     w128;
    logic [191:0]     w192, lng;
    logic [3:0]       off4, e4;
    logic [63:0]      fa, fb, sec, lane_val;

    wyh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .stat    (mstat)
    );

    always_comb begin
        rem      = total_reg - done_reg;
        avail    = bt_reg - done_reg;
        item_len = q_item.len[LEN_W-1:0];
        tail_off = total_reg - LEN_W'(ROUND_BYTES);
        fq       = (total_reg > LEN_W'(ROUND_BYTES)) ? tail_off[5:3] : 3'd0;
        w128     = {buf1_reg, buf0_reg};
        w192     = {rd0_reg, buf1_reg, buf0_reg};
        lng      = w192 >> {tail_off[2:0], 3'b000};
        off4     = {total_reg[4:3], 2'b00};
        e4       = 4'(total_reg[4:0] - 5'd4);
        case (lane_reg)
            2'd1:    begin sec = SECRET2; lane_val = second_reg; end
            2'd2:    begin sec = SECRET3; lane_val = third_reg;  end
            default: begin sec = SECRET1; lane_val = main_reg;   end
        endcase
        // Final operands: long tail, 4..16 bytes, 1..3 bytes, empty.
        if (total_reg > LEN_W'(ROUND_BYTES)) begin
            fa = lng[63:0];
            fb = lng[127:64];
        end else if (total_reg >= LEN_W'(4)) begin
            fa = {le4(w128, 4'd0), le4(w128, off4)};
            fb = {le4(w128, e4), le4(w128, 4'(e4 - off4))};
        end else if (total_reg != '0) begin
            fa = {40'd0, byte_at(w128, 4'd0), byte_at(w128, {3'd0, total_reg[1]}),
                  byte_at(w128, 4'(total_reg[1:0] - 2'd1))};
            fb = 64'd0;
        end else begin
            fa = 64'd0;
            fb = 64'd0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        total_next     = total_reg;
        bt_next        = bt_reg;
        done_next      = done_reg;
        main_next      = main_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        bulk_next      = bulk_reg;
        lane_next      = lane_reg;
        buf0_next      = buf0_reg;
        buf1_next      = buf1_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = bt_reg[5:3];
        ra0            = 3'd0;
        ra1            = 3'd1;
        mreq.start     = 1'b0;
        mreq.x         = 64'd0;
        mreq.y         = 64'd0;

        if (out_valid_reg && out_ready) out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.first) begin
                        total_next  = item_len;
                        done_next   = '0;
                        main_next   = q_item.seed ^ SECRET0;
                        second_next = q_item.seed ^ SECRET0;
                        third_next  = q_item.seed ^ SECRET0;
                        bulk_next   = item_len > LEN_W'(BLOCK_BYTES);
                        lane_next   = 2'd0;
                        if (q_item.empty) begin
                            bt_next    = '0;
                            state_next = ST_FRD0;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = 3'd0;
                            bt_next    = (item_len <= LEN_W'(8)) ? item_len : LEN_W'(8);
                            state_next = (item_len > LEN_W'(ROUND_BYTES)) ? ST_ADV : ST_CHECK;
                        end
                    end else if (bt_reg < total_reg) begin
                        wr_en      = 1'b1;
                        bt_next    = (total_reg - bt_reg <= LEN_W'(8)) ? total_reg
                                                                       : bt_reg + LEN_W'(8);
                        state_next = (total_reg > LEN_W'(ROUND_BYTES)) ? ST_ADV : ST_CHECK;
                    end
                end
            end
            ST_ADV: begin
                lane_next = 2'd0;
                if (bulk_reg) begin
                    if (rem > LEN_W'(BLOCK_BYTES)) begin
                        state_next = (avail < LEN_W'(BLOCK_BYTES)) ? ST_CHECK : ST_MRD;
                    end else begin
                        // Collapse the three lanes and fall into 16-byte rounds.
                        main_next = main_reg ^ second_reg ^ third_reg;
                        bulk_next = 1'b0;
                    end
                end else if (rem > LEN_W'(ROUND_BYTES) && avail >= LEN_W'(ROUND_BYTES)) begin
                    state_next = ST_MRD;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_MRD: begin
                ra0        = done_reg[5:3] + {lane_reg, 1'b0};
                ra1        = done_reg[5:3] + {lane_reg, 1'b1};
                state_next = ST_MGO;
            end
            ST_MGO: begin
                mreq.start = 1'b1;
                mreq.x     = rd0_reg ^ sec;
                mreq.y     = rd1_reg ^ lane_val;
                state_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mstat.done) begin
                    case (lane_reg)
                        2'd1:    second_next = mstat.result;
                        2'd2:    third_next  = mstat.result;
                        default: main_next   = mstat.result;
                    endcase
                    if (bulk_reg && lane_reg != 2'd2) begin
                        lane_next  = lane_reg + 2'd1;
                        state_next = ST_MRD;
                    end else begin
                        done_next  = done_reg + (bulk_reg ? LEN_W'(BLOCK_BYTES)
                                                          : LEN_W'(ROUND_BYTES));
                        state_next = ST_ADV;
                    end
                end
            end
            ST_CHECK: begin
                state_next = (bt_reg == total_reg) ? ST_FRD0 : ST_IDLE;
            end
            ST_FRD0: begin
                ra0        = fq;
                ra1        = fq + 3'd1;
                state_next = ST_FRD1;
            end
            ST_FRD1: begin
                buf0_next  = rd0_reg;
                buf1_next  = rd1_reg;
                ra0        = fq + 3'd2;
                state_next = ST_FOPS;
            end
            ST_FOPS: begin
                mreq.start = 1'b1;
                mreq.x     = fa ^ SECRET1;
                mreq.y     = fb ^ main_reg;
                state_next = ST_FM1W;
            end
            ST_FM1W: begin
                if (mstat.done) state_next = ST_FM2GO;
            end
            ST_FM2GO: begin
                mreq.start = 1'b1;
                mreq.x     = SECRET1 ^ 64'(total_reg);
                mreq.y     = mstat.result;
                state_next = ST_FM2W;
            end
            ST_FM2W: begin
                if (mstat.done) begin
                    state_next = ST_FOUT;
                end
            end
            ST_FOUT: begin
                // Hold the hash in the multiplier until the output register frees up.
                if (!out_valid_reg || out_ready) begin
                    out_data_next  = mstat.result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) win_mem[wr_addr] <= q_item.word;
        rd0_reg <= win_mem[ra0];
        rd1_reg <= win_mem[ra1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            bt_reg        <= '0;
            done_reg      <= '0;
            main_reg      <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            bulk_reg      <= 1'b0;
            lane_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            bt_reg        <= bt_next;
            done_reg      <= done_next;
            main_reg      <= main_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            bulk_reg      <= bulk_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg     <= buf0_next;
        buf1_reg     <= buf1_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_data_reg;

`ifndef SYNTHESIS
    a_bt_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        bt_reg <= total_reg) else $error("bytes received exceed length");
    a_done_le_bt: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= bt_reg) else $error("mixed past received bytes");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> !mstat.busy) else $error("multiplier started while busy");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mstat.busy) else $error("multiplier busy in idle");
`endif
endmodule

>>> hw/rtl/wyhash64_stream_hasher_core.sv
// wyhash64_stream_hasher_core: streaming 64-bit wyhash, default secrets.
// The two-entry queue accepts up to two words ahead of the sequencer while it mixes;
// each 16-byte round uses the shared multiply-fold unit once and each 48-byte block
// uses it once per lane.
// After the last word, any remaining rounds run, then two finishing multiplies give the hash.
// Reset: aresetn, synchronous, active low; clears queue, lanes, counters and
// output valid. The word window is not cleared.
module wyhash64_stream_hasher_core #(
    parameter int LEN_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] data_word, [95:64] msg_len, [159:96] seed_value
    input  logic [159:0] s_axis_tdata,
    // [0] first_word
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] hash_value
    output logic [63:0]  m_axis_tdata
);
    import wyh_pkg::*;

    item_t q_item;
    logic  q_valid, q_pop;

    // Front: take requests and queue them so the sequencer can stall freely.
    wyh_front #(.LEN_BITS(LEN_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata[63:0]),
        .in_len   (s_axis_tdata[95:64]),
        .in_seed  (s_axis_tdata[159:96]),
        .in_first (s_axis_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: store words, mix blocks and rounds, finish and hold the hash.
    wyh_back #(.LEN_BITS(LEN_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );
endmodule
